// ----- sv/agftc_pkg.sv -----
// Shared types, constants and the helper function of the ACK-gated flit transmit controller.
package agftc_pkg;

  localparam int CREDIT_W         = 7;
  localparam int MAX_BUFFER_DEPTH = 64;
  localparam logic [CREDIT_W-1:0] DEPTH_RESET = CREDIT_W'(4);

  typedef enum logic [1:0] {
    MODE_OPEN = 2'd0,
    MODE_MID  = 2'd1,
    MODE_WAIT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_DATA = 2'd1,
    SEL_ACK  = 2'd2
  } sel_t;

  typedef struct packed {
    logic data_valid;
    logic data_head;
    logic data_tail;
    logic data_ack_req;
    logic ack_waiting;
    logic credit_return;
    logic ack_arrived;
  } in_item_t;

  typedef struct packed {
    sel_t                send_select;
    logic [CREDIT_W-1:0] credits_left;
    mode_t               send_mode;
  } out_item_t;

  // Credit ceiling: the programmed depth clamped to the largest supported buffer.
  function automatic logic [CREDIT_W-1:0] credit_limit(input logic [CREDIT_W-1:0] depth);
    logic [CREDIT_W-1:0] lim;
    if (depth > CREDIT_W'(MAX_BUFFER_DEPTH)) begin
      lim = CREDIT_W'(MAX_BUFFER_DEPTH);
    end else begin
      lim = depth;
    end
    return lim;
  endfunction

endpackage

// ----- sv/agftc_in_reg.sv -----
// Input register stage that captures one tick's input transfer.
module agftc_in_reg import agftc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  logic     in_vld,
  input  in_item_t in_item,
  input  logic     drain,
  output logic     vld,
  output in_item_t item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = in_vld;
    end else if (drain) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// ----- sv/agftc_core.sv -----
// Send decision logic with the mode, packet flags, ACK tracking and credit counter.
module agftc_core import agftc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  in_item_t            item,
  input  logic                cfg_wr,
  input  logic [CREDIT_W-1:0] cfg_depth,
  output out_item_t           result
);

  mode_t               mode_r, mode_nxt;
  logic                sent_head_r, sent_head_nxt;
  logic                sent_tail_r, sent_tail_nxt;
  logic                ack_needed_r, ack_needed_nxt;
  logic                ack_seen_r, ack_seen_nxt;
  logic                ack_arrived_r, ack_arrived_nxt;
  logic                sent_last_r, sent_last_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  logic [CREDIT_W-1:0] depth_r, depth_nxt;

  logic                release_ok;
  logic [CREDIT_W:0]   credit_sum;
  logic [CREDIT_W:0]   credit_adj;
  logic [CREDIT_W-1:0] limit;
  logic [CREDIT_W-1:0] credits;
  sel_t                sel;

  assign limit = credit_limit(depth_r);

  always_comb begin
    // The seen latch is set by an arriving ACK and cleared by the next head sent.
    if (ack_seen_r) begin
      ack_seen_nxt = !sent_head_r;
    end else begin
      ack_seen_nxt = ack_arrived_r;
    end
    release_ok = !ack_needed_r || ack_arrived_r || ack_seen_nxt;

    unique case (mode_r)
      MODE_MID: begin
        if (sent_tail_r) begin
          mode_nxt = release_ok ? MODE_OPEN : MODE_WAIT;
        end else begin
          mode_nxt = MODE_MID;
        end
      end
      MODE_WAIT: begin
        mode_nxt = ack_arrived_r ? MODE_OPEN : MODE_WAIT;
      end
      default: begin
        if (sent_head_r) begin
          if (sent_tail_r) begin
            mode_nxt = release_ok ? MODE_OPEN : MODE_WAIT;
          end else begin
            mode_nxt = MODE_MID;
          end
        end else begin
          mode_nxt = MODE_OPEN;
        end
      end
    endcase

    // Debit the previous send, credit this tick's return, then saturate.
    credit_sum = {1'b0, credit_r} + (CREDIT_W+1)'(item.credit_return);
    if (sent_last_r && (credit_sum == '0)) begin
      credit_adj = '0;
    end else begin
      credit_adj = credit_sum - (CREDIT_W+1)'(sent_last_r);
    end
    if (credit_adj > {1'b0, limit}) begin
      credits = limit;
    end else begin
      credits = credit_adj[CREDIT_W-1:0];
    end

    sel = SEL_NONE;
    if (credits != '0) begin
      unique case (mode_nxt)
        MODE_OPEN: begin
          if (item.ack_waiting) begin
            sel = SEL_ACK;
          end else if (item.data_valid) begin
            sel = SEL_DATA;
          end
        end
        MODE_MID: begin
          if (item.data_valid) begin
            sel = SEL_DATA;
          end
        end
        default: begin
          sel = SEL_NONE;
        end
      endcase
    end

    sent_tail_nxt   = (sel == SEL_DATA) && item.data_tail;
    sent_head_nxt   = (sel == SEL_DATA) && item.data_head;
    ack_needed_nxt  = sent_head_nxt ? item.data_ack_req : ack_needed_r;
    ack_arrived_nxt = item.ack_arrived;
    sent_last_nxt   = (sel != SEL_NONE);
    credit_nxt      = credits;
    depth_nxt       = depth_r;

    result.send_select  = sel;
    result.credits_left = credits;
    result.send_mode    = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_OPEN;
      sent_head_r   <= 1'b0;
      sent_tail_r   <= 1'b0;
      ack_needed_r  <= 1'b0;
      ack_seen_r    <= 1'b1;
      ack_arrived_r <= 1'b0;
      sent_last_r   <= 1'b0;
      depth_r       <= DEPTH_RESET;
      credit_r      <= credit_limit(DEPTH_RESET);
    end else if (cfg_wr) begin
      // A depth write also reloads the credit count with the new ceiling.
      depth_r  <= cfg_depth;
      credit_r <= credit_limit(cfg_depth);
    end else if (step) begin
      mode_r        <= mode_nxt;
      sent_head_r   <= sent_head_nxt;
      sent_tail_r   <= sent_tail_nxt;
      ack_needed_r  <= ack_needed_nxt;
      ack_seen_r    <= ack_seen_nxt;
      ack_arrived_r <= ack_arrived_nxt;
      sent_last_r   <= sent_last_nxt;
      credit_r      <= credit_nxt;
      depth_r       <= depth_nxt;
    end
  end

endmodule

// ----- sv/agftc_out_reg.sv -----
// Result register that holds one send decision until the downstream side takes it.
module agftc_out_reg import agftc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t result,
  input  logic      stall,
  output logic      vld,
  output logic      ready,
  output out_item_t item
);

  logic      vld_r, vld_nxt;
  out_item_t item_r;

  assign ready = !vld_r || !stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// ----- sv/ack_gated_flit_transmit_control.sv -----
// Top level of the ACK-gated flit transmit controller: input stage, decision core, result stage.
// Each input transfer is one clock tick of the link. It is captured in an input register,
// decided by the core once the result register can take it and written to that register, so
// one item enters and one result leaves per cycle while out_stall stays low; the loop
// through the mode, flag and credit registers in the core sets that rate. Either
// register holds its contents while the side after it stalls. The buffer depth register
// may be written at any time the block is idle; the write also reloads the credit counter.
module ack_gated_flit_transmit_control import agftc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_data_valid,
  input  logic                in_data_head,
  input  logic                in_data_tail,
  input  logic                in_data_ack_req,
  input  logic                in_ack_waiting,
  input  logic                in_credit_return,
  input  logic                in_ack_arrived,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_send_select,
  output logic [CREDIT_W-1:0] out_credits_left,
  output logic [1:0]          out_send_mode,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CREDIT_W-1:0] cfg_buffer_depth
);

  in_item_t  in_item;
  in_item_t  s1_item;
  logic      s1_vld;
  logic      out_ready;
  logic      step;
  logic      load_in;
  out_item_t core_result;
  out_item_t out_item;

  assign in_item = '{
    data_valid:    in_data_valid,
    data_head:     in_data_head,
    data_tail:     in_data_tail,
    data_ack_req:  in_data_ack_req,
    ack_waiting:   in_ack_waiting,
    credit_return: in_credit_return,
    ack_arrived:   in_ack_arrived
  };

  assign step     = s1_vld && out_ready;
  assign in_stall = s1_vld && !out_ready;
  assign load_in  = !in_stall;
  assign cfg_ready = 1'b1;

  agftc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load_in),
    .in_vld  (in_valid),
    .in_item (in_item),
    .drain   (step),
    .vld     (s1_vld),
    .item    (s1_item)
  );

  agftc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_depth (cfg_buffer_depth),
    .result    (core_result)
  );

  agftc_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (step),
    .result (core_result),
    .stall  (out_stall),
    .vld    (out_valid),
    .ready  (out_ready),
    .item   (out_item)
  );

  assign out_send_select  = out_item.send_select;
  assign out_credits_left = out_item.credits_left;
  assign out_send_mode    = out_item.send_mode;

endmodule
